// ----- hw/rtl/tmsh_pkg.sv -----
package tmsh_pkg;

    // Seed reload values
    localparam logic [31:0] SEED_A_INIT = 32'h7FED_7FED;
    localparam logic [31:0] SEED_B_INIT = 32'hEEEF_EEEF;
    localparam logic [31:0] SEED_B_BIAS = 32'd3;

    // Generator for the mixing table
    localparam logic [31:0] LCG_START = 32'h0010_0001;
    localparam logic [31:0] LCG_MUL   = 32'd125;
    localparam logic [31:0] LCG_ADD   = 32'd3;
    localparam logic [31:0] LCG_MOD   = 32'h002A_AAAB;
    localparam int          SECTIONS      = 5;
    localparam int          TABLE_SECTION = 2;
    localparam int          TABLE_DEPTH   = 256;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef logic [TABLE_DEPTH-1:0][31:0] mix_table_t;

    // One queued transaction, with its table word already looked up
    typedef struct packed {
        logic [31:0] mix_word;
        logic [7:0]  data_byte;
        logic        byte_present;
        logic        first_byte;
        logic        last_byte;
    } item_t;

    // Build the kept section of the generated table at elaboration
    function automatic mix_table_t build_mix_table();
        mix_table_t  tbl;
        logic [31:0] s;
        logic [31:0] hi;
        logic [31:0] lo;
        int          want;
        tbl  = '0;
        s    = LCG_START;
        want = TABLE_SECTION % SECTIONS;
        for (int b = 0; b < TABLE_DEPTH; b++) begin
            for (int k = 0; k < SECTIONS; k++) begin
                s  = (s * LCG_MUL + LCG_ADD) % LCG_MOD;
                hi = {s[15:0], 16'h0000};
                s  = (s * LCG_MUL + LCG_ADD) % LCG_MOD;
                lo = {16'h0000, s[15:0]};
                if (k == want) begin
                    tbl[b] = hi | lo;
                end
            end
        end
        return tbl;
    endfunction

    localparam mix_table_t MIX_TABLE = build_mix_table();

endpackage

// ----- hw/rtl/tmsh_front.sv -----
module tmsh_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_data_byte,
    input  logic            s_byte_present,
    input  logic            s_first_byte,
    input  logic            s_last_byte,
    output logic            push_valid,
    input  logic            push_ready,
    output tmsh_pkg::item_t push_item
);
    import tmsh_pkg::*;

    logic  front_valid_reg;
    logic  front_valid_next;
    item_t front_item_reg;
    item_t front_item_next;
    logic  accept;
    logic  keep;

    assign s_ready    = !front_valid_reg || push_ready;
    assign accept     = s_valid && s_ready;
    assign push_valid = front_valid_reg;
    assign push_item  = front_item_reg;

    // Drop transactions that neither reload, hash nor finish a string
    assign keep = s_byte_present || s_first_byte || s_last_byte;

    // Look up the table word and stage the transaction
    always_comb begin
        front_valid_next = front_valid_reg;
        front_item_next  = front_item_reg;
        if (accept) begin
            front_valid_next             = keep;
            front_item_next.mix_word     = MIX_TABLE[s_data_byte];
            front_item_next.data_byte    = s_data_byte;
            front_item_next.byte_present = s_byte_present;
            front_item_next.first_byte   = s_first_byte;
            front_item_next.last_byte    = s_last_byte;
        end else if (push_ready) begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else begin
            front_valid_reg <= front_valid_next;
        end
        front_item_reg <= front_item_next;
    end

endmodule

// ----- hw/rtl/tmsh_queue.sv -----
module tmsh_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  tmsh_pkg::item_t push_item,
    output logic            head_valid,
    input  logic            pop,
    output tmsh_pkg::item_t head_item
);
    import tmsh_pkg::*;

    item_t                entries_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_AW:0]    count_reg;
    logic [QUEUE_AW:0]    count_next;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = (count_reg != QUEUE_DEPTH[QUEUE_AW:0]);
    assign head_valid = (count_reg != '0);
    assign head_item  = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    // Track occupancy
    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Store the transaction at the write pointer
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- hw/rtl/tmsh_back.sv -----
module tmsh_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            head_valid,
    input  tmsh_pkg::item_t head_item,
    output logic            pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [31:0]     m_hash_value
);
    import tmsh_pkg::*;

    logic [31:0] seed_a_reg;
    logic [31:0] seed_b_reg;
    logic [31:0] seed_a_next;
    logic [31:0] seed_b_next;
    logic        m_valid_reg;
    logic        m_valid_next;
    logic [31:0] hash_reg;
    logic [31:0] hash_next;
    logic [31:0] base_a;
    logic [31:0] base_b;
    logic [31:0] mixed_a;
    logic [31:0] mixed_b;

    // Take the head unless it must emit and the output is still held
    assign pop = head_valid && (!head_item.last_byte || !m_valid_reg || m_ready);

    assign m_valid      = m_valid_reg;
    assign m_hash_value = hash_reg;

    // Seed update for one byte
    always_comb begin
        base_a  = head_item.first_byte ? SEED_A_INIT : seed_a_reg;
        base_b  = head_item.first_byte ? SEED_B_INIT : seed_b_reg;
        mixed_a = head_item.mix_word ^ (base_a + base_b);
        mixed_b = mixed_a + base_b + {base_b[26:0], 5'b00000}
                + {24'h000000, head_item.data_byte} + SEED_B_BIAS;
    end

    // Advance the seeds and load the output register
    always_comb begin
        seed_a_next  = seed_a_reg;
        seed_b_next  = seed_b_reg;
        m_valid_next = m_valid_reg;
        hash_next    = hash_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (pop) begin
            seed_a_next = head_item.byte_present ? mixed_a : base_a;
            seed_b_next = head_item.byte_present ? mixed_b : base_b;
            if (head_item.last_byte) begin
                m_valid_next = 1'b1;
                hash_next    = head_item.byte_present ? mixed_a : base_a;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_a_reg  <= SEED_A_INIT;
            seed_b_reg  <= SEED_B_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            seed_a_reg  <= seed_a_next;
            seed_b_reg  <= seed_b_next;
            m_valid_reg <= m_valid_next;
        end
        hash_reg <= hash_next;
    end

endmodule

// ----- hw/rtl/table_mixed_string_hash_top.sv -----
// Channel  Direction  Handshake          Payload
// s_       in         s_valid/s_ready    data_byte, byte_present, first_byte, last_byte
// m_       out        m_valid/m_ready    hash_value
//
// One byte per cycle sustained while the output is not stalled at a string end;
// the seed register feedback in the back stage is the loop that sets this rate.
// With an empty queue, a last byte passes the front register and queue to m_valid.
// Reset (aresetn low, synchronous) empties the queue and reloads both seeds.
// A stalled output holds the back stage only on a string end; the four-entry
// queue and the front register absorb input meanwhile.
module table_mixed_string_hash_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_byte_present,
    input  logic        s_first_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_hash_value
);
    import tmsh_pkg::*;

    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  head_valid;
    logic  pop;
    item_t head_item;

    tmsh_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_byte_present (s_byte_present),
        .s_first_byte   (s_first_byte),
        .s_last_byte    (s_last_byte),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_item      (push_item)
    );

    tmsh_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .head_valid (head_valid),
        .pop        (pop),
        .head_item  (head_item)
    );

    tmsh_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_valid   (head_valid),
        .head_item    (head_item),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

endmodule
